// File: sv/brdr_pkg.sv
// brdr_pkg: shared constants, character codes, command word type and helpers
// for the bracket depth reindenter. No dependencies.
`timescale 1ns / 1ps

package brdr_pkg;

  localparam int INDENT_WIDTH = 8;
  localparam int MAX_DEPTH    = 63;
  localparam int MAX_COLUMN   = 1023;

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int COL_W   = $clog2(MAX_COLUMN + 1);
  // wide enough for column + indent of the deepest level + 2 levels
  localparam int SUM_W   = $clog2(MAX_COLUMN + INDENT_WIDTH * (MAX_DEPTH + 2) + 2) + 1;
  localparam int CNT_W   = 10;
  localparam int RUN_MAX = 1023;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] ACT_TEXT = 2'd0;
  localparam logic [1:0] ACT_EOL  = 2'd1;
  localparam logic [1:0] ACT_MORE = 2'd2;
  localparam logic [1:0] ACT_LESS = 2'd3;

  localparam logic [7:0] CH_ALIGN  = 8'h01;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // one command word per input that produces output: optional tab run,
  // optional space run, then the byte itself
  typedef struct packed {
    logic             has_tab;
    logic [CNT_W-1:0] tab_cnt;
    logic             has_sp;
    logic [CNT_W-1:0] sp_cnt;
    logic [7:0]       chr;
  } cmd_t;

  function automatic logic [COL_W-1:0] col_sat(input logic [SUM_W-1:0] v);
    return (v > SUM_W'(MAX_COLUMN)) ? COL_W'(MAX_COLUMN) : COL_W'(v);
  endfunction

  function automatic logic [CNT_W-1:0] run_sat(input logic [COL_W-1:0] v);
    logic [SUM_W-1:0] ext;
    ext = SUM_W'(v);
    return (ext > SUM_W'(RUN_MAX)) ? CNT_W'(RUN_MAX) : CNT_W'(v);
  endfunction

endpackage

// File: sv/brdr_front.sv
// brdr_front: per-item classifier; tracks depth, columns and continuation
// and turns each input into at most one command word. Uses brdr_pkg.
`timescale 1ns / 1ps

module brdr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [1:0]        action,
  input  logic [7:0]        in_chr,
  output logic              cmd_push,
  output brdr_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    CONT_NONE   = 3'b001,
    CONT_BSLASH = 3'b010,
    CONT_LINE   = 3'b100
  } cont_t;

  logic [brdr_pkg::DEPTH_W-1:0] depth_r, depth_nxt;
  logic [brdr_pkg::COL_W-1:0]   icol_r, icol_nxt;
  logic [brdr_pkg::COL_W-1:0]   ocol_r, ocol_nxt;
  cont_t                        cont_r, cont_nxt;

  logic                         emit;
  logic [brdr_pkg::DEPTH_W-1:0] d1;
  logic [brdr_pkg::COL_W-1:0]   ic1, oc1, tabs, spaces;
  logic [brdr_pkg::SUM_W-1:0]   target;
  logic                         sol;

  always_comb begin
    depth_nxt = depth_r;
    icol_nxt  = icol_r;
    ocol_nxt  = ocol_r;
    cont_nxt  = cont_r;
    emit      = 1'b0;
    cmd       = '0;
    d1        = depth_r;
    ic1       = icol_r;
    oc1       = ocol_r;
    tabs      = '0;
    spaces    = '0;
    target    = '0;
    sol       = (ocol_r == '0);

    case (action)
      brdr_pkg::ACT_TEXT: begin
        case (in_chr)
          brdr_pkg::CH_NL: begin
            emit      = 1'b1;
            cmd.chr   = brdr_pkg::CH_NL;
            icol_nxt  = '0;
            ocol_nxt  = '0;
            cont_nxt  = (cont_r == CONT_BSLASH) ? CONT_LINE : CONT_NONE;
          end
          brdr_pkg::CH_SP: begin
            if (!sol)
              icol_nxt = brdr_pkg::col_sat(brdr_pkg::SUM_W'(icol_r) + 1'b1);
          end
          brdr_pkg::CH_TAB: begin
            if (!sol)
              icol_nxt = brdr_pkg::col_sat(
                  (brdr_pkg::SUM_W'(icol_r / brdr_pkg::INDENT_WIDTH) + 1'b1) *
                  brdr_pkg::SUM_W'(brdr_pkg::INDENT_WIDTH));
          end
          brdr_pkg::CH_ALIGN: begin
            target = brdr_pkg::SUM_W'(brdr_pkg::col_sat(
                brdr_pkg::SUM_W'(brdr_pkg::INDENT_WIDTH) *
                (brdr_pkg::SUM_W'(depth_r) + 2'd2)));
            if (!sol) begin
              if (brdr_pkg::SUM_W'(icol_r) >= target)
                icol_nxt = brdr_pkg::col_sat(brdr_pkg::SUM_W'(icol_r) + 1'b1);
              else
                icol_nxt = brdr_pkg::COL_W'(target);
            end
          end
          default: begin
            emit = 1'b1;
            if ((in_chr inside {brdr_pkg::CH_RBRACE, brdr_pkg::CH_RPAREN,
                                brdr_pkg::CH_RBRACK}) && depth_r != '0)
              d1 = depth_r - 1'b1;
            // indentation at start of line, except preprocessor and continued lines
            if (sol && in_chr != brdr_pkg::CH_HASH && cont_r != CONT_LINE)
              ic1 = brdr_pkg::col_sat(brdr_pkg::SUM_W'(icol_r) +
                    brdr_pkg::SUM_W'(brdr_pkg::INDENT_WIDTH) * brdr_pkg::SUM_W'(d1));
            if (sol) begin
              if (brdr_pkg::INDENT_WIDTH == 1) begin
                tabs = (ic1 >= brdr_pkg::COL_W'(2)) ? ic1 - 1'b1 : '0;
                oc1  = tabs;
              end else begin
                tabs = brdr_pkg::COL_W'(ic1 / brdr_pkg::INDENT_WIDTH);
                oc1  = brdr_pkg::COL_W'(brdr_pkg::SUM_W'(tabs) *
                       brdr_pkg::SUM_W'(brdr_pkg::INDENT_WIDTH));
              end
            end
            spaces       = ic1 - oc1;
            cmd.has_tab  = (tabs != '0);
            cmd.tab_cnt  = brdr_pkg::run_sat(tabs);
            cmd.has_sp   = (spaces != '0);
            cmd.sp_cnt   = brdr_pkg::run_sat(spaces);
            cmd.chr      = in_chr;
            depth_nxt    = d1;
            if ((in_chr inside {brdr_pkg::CH_LBRACE, brdr_pkg::CH_LPAREN,
                                brdr_pkg::CH_LBRACK}) &&
                d1 != brdr_pkg::DEPTH_W'(brdr_pkg::MAX_DEPTH))
              depth_nxt = d1 + 1'b1;
            icol_nxt = brdr_pkg::col_sat(brdr_pkg::SUM_W'(ic1) + 1'b1);
            ocol_nxt = icol_nxt;
            cont_nxt = (in_chr == brdr_pkg::CH_BSLASH) ? CONT_BSLASH : CONT_NONE;
          end
        endcase
      end
      brdr_pkg::ACT_EOL: begin
        if (icol_r != '0) begin
          emit     = 1'b1;
          cmd.chr  = brdr_pkg::CH_NL;
          icol_nxt = '0;
          ocol_nxt = '0;
          cont_nxt = (cont_r == CONT_BSLASH) ? CONT_LINE : CONT_NONE;
        end
      end
      brdr_pkg::ACT_MORE: begin
        if (depth_r != brdr_pkg::DEPTH_W'(brdr_pkg::MAX_DEPTH))
          depth_nxt = depth_r + 1'b1;
      end
      brdr_pkg::ACT_LESS: begin
        if (depth_r != '0)
          depth_nxt = depth_r - 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign cmd_push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      icol_r  <= '0;
      ocol_r  <= '0;
      cont_r  <= CONT_NONE;
    end else if (accept) begin
      depth_r <= depth_nxt;
      icol_r  <= icol_nxt;
      ocol_r  <= ocol_nxt;
      cont_r  <= cont_nxt;
    end
  end

  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= brdr_pkg::DEPTH_W'(brdr_pkg::MAX_DEPTH))
    else $error("nest depth out of range");

  a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
    ocol_r <= icol_r)
    else $error("output column ahead of input column");

  a_nl_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push && cmd.chr == brdr_pkg::CH_NL && !cmd.has_tab && !cmd.has_sp
    |=> icol_r == '0 && ocol_r == '0)
    else $error("columns not cleared after newline");

endmodule

// File: sv/brdr_cmd_fifo.sv
// brdr_cmd_fifo: short register queue of command words between front and back.
// Uses brdr_pkg.
`timescale 1ns / 1ps

module brdr_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  brdr_pkg::cmd_t wr_data,
  input  logic           rd_en,
  output brdr_pkg::cmd_t rd_data,
  output logic           full,
  output logic           empty
);

  brdr_pkg::cmd_t                mem_r [brdr_pkg::FIFO_DEPTH];
  logic [brdr_pkg::FIFO_AW-1:0]  wptr_r, wptr_nxt;
  logic [brdr_pkg::FIFO_AW-1:0]  rptr_r, rptr_nxt;
  logic [brdr_pkg::FIFO_CW-1:0]  cnt_r, cnt_nxt;

  assign full    = (cnt_r == brdr_pkg::FIFO_CW'(brdr_pkg::FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (wr_en)
      wptr_nxt = (wptr_r == brdr_pkg::FIFO_AW'(brdr_pkg::FIFO_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    if (rd_en)
      rptr_nxt = (rptr_r == brdr_pkg::FIFO_AW'(brdr_pkg::FIFO_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    if (wr_en && !rd_en)
      cnt_nxt = cnt_r + 1'b1;
    else if (rd_en && !wr_en)
      cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en)
      mem_r[wptr_r] <= wr_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && full && !rd_en))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && empty))
    else $error("command queue underflow");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= brdr_pkg::FIFO_CW'(brdr_pkg::FIFO_DEPTH))
    else $error("command queue count out of range");

endmodule

// File: sv/brdr_back.sv
// brdr_back: expands each command word into tab run, space run and byte words
// into a one-entry output register. Uses brdr_pkg.
`timescale 1ns / 1ps

module brdr_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_empty,
  input  brdr_pkg::cmd_t             cmd,
  output logic                       cmd_pop,
  input  logic                       out_take,
  output logic                       out_valid,
  output logic [7:0]                 out_chr,
  output logic [brdr_pkg::CNT_W-1:0] out_cnt,
  output logic                       out_end
);

  logic                        tab_done_r, tab_done_nxt;
  logic                        sp_done_r, sp_done_nxt;
  logic                        vld_r, vld_nxt;
  logic [7:0]                  chr_r, chr_nxt;
  logic [brdr_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        end_r, end_nxt;
  logic                        load;

  // slot free when empty or its word leaves this cycle
  assign load = !cmd_empty && (!vld_r || out_take);

  always_comb begin
    tab_done_nxt = tab_done_r;
    sp_done_nxt  = sp_done_r;
    chr_nxt      = chr_r;
    cnt_nxt      = cnt_r;
    end_nxt      = end_r;
    cmd_pop      = 1'b0;
    vld_nxt      = out_take ? 1'b0 : vld_r;
    if (load) begin
      vld_nxt = 1'b1;
      if (cmd.has_tab && !tab_done_r) begin
        chr_nxt      = brdr_pkg::CH_TAB;
        cnt_nxt      = cmd.tab_cnt;
        end_nxt      = 1'b0;
        tab_done_nxt = 1'b1;
      end else if (cmd.has_sp && !sp_done_r) begin
        chr_nxt     = brdr_pkg::CH_SP;
        cnt_nxt     = cmd.sp_cnt;
        end_nxt     = 1'b0;
        sp_done_nxt = 1'b1;
      end else begin
        chr_nxt      = cmd.chr;
        cnt_nxt      = brdr_pkg::CNT_W'(1);
        end_nxt      = 1'b1;
        cmd_pop      = 1'b1;
        tab_done_nxt = 1'b0;
        sp_done_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= 1'b0;
      tab_done_r <= 1'b0;
      sp_done_r  <= 1'b0;
    end else begin
      vld_r      <= vld_nxt;
      tab_done_r <= tab_done_nxt;
      sp_done_r  <= sp_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chr_r <= chr_nxt;
    cnt_r <= cnt_nxt;
    end_r <= end_nxt;
  end

  assign out_valid = vld_r;
  assign out_chr   = chr_r;
  assign out_cnt   = cnt_r;
  assign out_end   = end_r;

  a_pop_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> load)
    else $error("command popped without loading a word");

  a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> !tab_done_r && !sp_done_r && vld_r && end_r)
    else $error("progress flags not cleared after final word");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> cnt_r != '0)
    else $error("run word with zero count");

endmodule

// File: sv/bracket_depth_reindenter_core.sv
// bracket_depth_reindenter_core: top level of the reindenter.
// Depends on brdr_pkg, brdr_front, brdr_cmd_fifo and brdr_back.
`timescale 1ns / 1ps

// Usage:
//   Input queue: drive in_action/in_byte and raise push; a word is taken at
//   a clock edge where push is high and full is low. Text bytes, end of line,
//   indent more and indent less are all one word each.
//   Result queue: while empty is low, out_byte/out_repeat_count/out_last hold
//   the oldest run word (tab run, space run, then the byte); pop high with
//   empty low takes it. out_last marks the final word of one input.
// Path: with the result side idle, an accepted input writes its command word
//   into the command queue, and the back then loads its first result word
//   from the queue head into the output register.
// Throughput: the front takes one input per cycle while full is low; the back
//   sends one result word per cycle while pop is high and words are queued.
//   Inputs that yield nothing (spaces, tabs, depth changes) skip the back.
// Stall: when pop stays low the output register holds its word, the four
//   entry command queue fills and full rises, pausing the input side.
// Reset: rst_n low at a clock edge clears depth, columns, continuation,
//   the command queue and the output register; empty goes high, full low.

module bracket_depth_reindenter_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 in_action,
  input  logic [7:0]                 in_byte,
  output logic                       empty,
  input  logic                       pop,
  output logic [7:0]                 out_byte,
  output logic [brdr_pkg::CNT_W-1:0] out_repeat_count,
  output logic                       out_last
);

  logic           accept;
  logic           cmd_push;
  brdr_pkg::cmd_t cmd_in;
  brdr_pkg::cmd_t cmd_head;
  logic           cmd_pop;
  logic           cmd_empty;
  logic           out_valid;
  logic           out_take;

  assign accept   = push && !full;
  assign empty    = !out_valid;
  assign out_take = pop && out_valid;

  // front: state tracking and classification, one input per cycle while full is low
  brdr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .action   (in_action),
    .in_chr   (in_byte),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  // decouples the front from a stalled result side
  brdr_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .rd_en   (cmd_pop),
    .rd_data (cmd_head),
    .full    (full),
    .empty   (cmd_empty)
  );

  // back: run word expansion into the output register
  brdr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_take  (out_take),
    .out_valid (out_valid),
    .out_chr   (out_byte),
    .out_cnt   (out_repeat_count),
    .out_end   (out_last)
  );

endmodule

// File: sim/tb_top.sv
// tb_top: self-checking testbench for bracket_depth_reindenter_core.
// Depends on brdr_pkg and the reindenter RTL; holds its own model of the reindenter.
`timescale 1ns / 1ps

module tb_top;
  import brdr_pkg::*;

  // continuation tracking codes
  localparam int CONT_NONE   = 0;  // nothing pending
  localparam int CONT_BSLASH = 1;  // last byte was a backslash
  localparam int CONT_LINE   = 2;  // this line continues the previous one

  localparam int STALL_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int SETTLE      = 20;    // quiet cycles after the last run word

  // one expected run word: byte, repeat count, end-of-input marker
  typedef struct packed {
    logic [7:0]       chr;
    logic [CNT_W-1:0] cnt;
    logic             last;
  } run_word_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             push      = 1'b0;
  logic [1:0]       in_action = ACT_TEXT;
  logic [7:0]       in_byte   = 8'h00;
  logic             pop       = 1'b0;
  logic             full;
  logic             empty;
  logic [7:0]       out_byte;
  logic [CNT_W-1:0] out_repeat_count;
  logic             out_last;

  // model state: nesting depth, logical and physical column, continuation
  int nest    = 0;
  int in_col  = 0;
  int out_col = 0;
  int cont    = CONT_NONE;

  run_word_t run_q[$];  // run words predicted but not yet popped

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int words_sent    = 0;
  int runs_checked  = 0;
  int deepest       = 0;
  int widest_col    = 0;
  int col_sat_hits  = 0;
  int stall_cycles  = 0;

  always #5 clk = ~clk;

  bracket_depth_reindenter_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_action        (in_action),
    .in_byte          (in_byte),
    .empty            (empty),
    .pop              (pop),
    .out_byte         (out_byte),
    .out_repeat_count (out_repeat_count),
    .out_last         (out_last)
  );

  // ---------------------------------------------------------------------
  // Reindent model
  // ---------------------------------------------------------------------

  function automatic int limit_column(input int v);
    if (v > MAX_COLUMN) col_sat_hits++;
    return (v > MAX_COLUMN) ? MAX_COLUMN : v;
  endfunction

  function automatic void add_run(input logic [7:0] c, input int n);
    run_word_t w;
    w.chr  = c;
    w.cnt  = CNT_W'((n > RUN_MAX) ? RUN_MAX : n);
    w.last = 1'b0;
    run_q.push_back(w);
  endfunction

  function automatic void put_newline();
    add_run(CH_NL, 1);
    in_col  = 0;
    out_col = 0;
    cont    = (cont == CONT_BSLASH) ? CONT_LINE : CONT_NONE;
  endfunction

  // visible byte: pay out deferred whitespace, then the byte
  function automatic void put_text(input logic [7:0] c);
    int tabs;
    tabs = 0;
    if (c == CH_RBRACE || c == CH_RPAREN || c == CH_RBRACK) begin
      if (nest > 0) nest--;
    end
    // depth indent unless a preprocessor line or a continued line
    if (out_col == 0 && c != CH_HASH && cont != CONT_LINE)
      in_col = limit_column(in_col + INDENT_WIDTH * nest);
    // tabs only at the start of a line, never overshooting the target
    if (out_col == 0) begin
      while (out_col + 1 < in_col && (out_col / INDENT_WIDTH + 1) * INDENT_WIDTH <= in_col) begin
        tabs++;
        out_col = (out_col / INDENT_WIDTH + 1) * INDENT_WIDTH;
      end
    end
    if (tabs > 0) add_run(CH_TAB, tabs);
    if (out_col < in_col) add_run(CH_SP, in_col - out_col);
    if (c == CH_LBRACE || c == CH_LPAREN || c == CH_LBRACK) begin
      if (nest < MAX_DEPTH) nest++;
    end
    add_run(c, 1);
    in_col  = limit_column(in_col + 1);
    out_col = in_col;
    cont    = (c == CH_BSLASH) ? CONT_BSLASH : CONT_NONE;
  endfunction

  function automatic void take_text_byte(input logic [7:0] b);
    int goal;
    if (b == CH_NL) begin
      put_newline();
    end else if (b == CH_SP) begin
      if (out_col != 0) in_col = limit_column(in_col + 1);
    end else if (b == CH_TAB) begin
      if (out_col != 0) in_col = limit_column((in_col / INDENT_WIDTH + 1) * INDENT_WIDTH);
    end else if (b == CH_ALIGN) begin
      // align two levels past the current depth, or just step one column
      if (out_col != 0) begin
        goal   = limit_column(INDENT_WIDTH * (nest + 2));
        in_col = (in_col >= goal) ? limit_column(in_col + 1) : goal;
      end
    end else begin
      put_text(b);
    end
  endfunction

  // called once per accepted input word; appends its run words to run_q
  function automatic void reindent_word(input logic [1:0] act, input logic [7:0] b);
    int first;
    first = run_q.size();
    case (act)
      ACT_TEXT: take_text_byte(b);
      ACT_EOL:  if (in_col != 0) put_newline();
      ACT_MORE: if (nest < MAX_DEPTH) nest++;
      ACT_LESS: if (nest > 0) nest--;
    endcase
    if (run_q.size() > first) run_q[run_q.size() - 1].last = 1'b1;
    if (nest > deepest) deepest = nest;
    if (in_col > widest_col) widest_col = in_col;
  endfunction

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Drives one word and returns at the edge that takes it, push still high;
  // the next call either keeps it high or drops it for a gap.
  task automatic send_word(input logic [1:0] act, input logic [7:0] b);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    push      <= 1'b1;
    in_action <= act;
    in_byte   <= b;
    do @(posedge clk); while (full);
    reindent_word(act, b);
    words_sent++;
  endtask

  // stop sending and wait until every predicted run word has been popped
  task automatic drain();
    push <= 1'b0;
    while (run_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Result side: random pop, field-by-field compare against run_q
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] ERROR: %s", $time, msg);
  endtask

  always @(posedge clk) begin : check_runs
    run_word_t w;
    if (rst_n && pop && !empty) begin
      if (run_q.size() == 0) begin
        report_mismatch($sformatf("unexpected run word byte %02h count %0d last %0b",
                                  out_byte, out_repeat_count, out_last));
      end else begin
        w = run_q.pop_front();
        runs_checked++;
        if (out_byte !== w.chr)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, w.chr));
        if (out_repeat_count !== w.cnt)
          report_mismatch($sformatf("out_repeat_count %0d, want %0d (byte %02h)",
                                    out_repeat_count, w.cnt, w.chr));
        if (out_last !== w.last)
          report_mismatch($sformatf("out_last %0b, want %0b (byte %02h)",
                                    out_last, w.last, w.chr));
      end
    end
    pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog: nothing moving on either side for too long ends the run
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] Timeout: no word moved in %0d cycles, %0d run words pending",
               $time, STALL_LIMIT, run_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // field extremes, every action, whitespace rules, brackets, '#',
  // backslash continuation and depth underflow
  task automatic test_directed();
    send_word(ACT_EOL,  8'hFF);      // empty line: nothing, byte ignored
    send_word(ACT_LESS, 8'h00);      // depth stays at zero
    send_word(ACT_TEXT, CH_SP);      // leading whitespace is dropped
    send_word(ACT_TEXT, CH_TAB);
    send_word(ACT_TEXT, CH_ALIGN);
    send_word(ACT_TEXT, CH_RPAREN);  // closer at depth zero
    send_word(ACT_TEXT, CH_SP);      // deferred space
    send_word(ACT_TEXT, CH_TAB);     // deferred tab stop
    send_word(ACT_TEXT, CH_ALIGN);   // jumps to two levels out
    send_word(ACT_TEXT, CH_ALIGN);   // already past it: one column
    send_word(ACT_TEXT, 8'hFF);      // pays out the space run
    send_word(ACT_TEXT, CH_LBRACE);
    send_word(ACT_TEXT, CH_LPAREN);
    send_word(ACT_TEXT, CH_LBRACK);
    send_word(ACT_EOL,  8'h5A);
    send_word(ACT_TEXT, CH_RBRACE);  // lowers depth, then tab indent
    send_word(ACT_TEXT, CH_NL);
    send_word(ACT_TEXT, CH_HASH);    // preprocessor line: no indent
    send_word(ACT_TEXT, CH_BSLASH);
    send_word(ACT_TEXT, CH_NL);      // next line is a continuation
    send_word(ACT_TEXT, 8'h00);      // continued line: no indent
    send_word(ACT_MORE, 8'hFF);
    send_word(ACT_EOL,  8'h00);
    send_word(ACT_TEXT, CH_RBRACK);
    send_word(ACT_TEXT, CH_RPAREN);
    send_word(ACT_EOL,  8'hAA);
  endtask

  // one random token of a code line, with the odd stray word mixed in
  task automatic send_token();
    logic [7:0] b;
    case ($urandom_range(0, 13))
      0, 1, 2, 3: b = 8'($urandom_range(8'h61, 8'h7A));  // identifier letter
      4: b = ($urandom_range(0, 2) == 0) ? CH_LBRACE :
             ($urandom_range(0, 1) == 0) ? CH_LPAREN : CH_LBRACK;
      5: b = ($urandom_range(0, 2) == 0) ? CH_RBRACE :
             ($urandom_range(0, 1) == 0) ? CH_RPAREN : CH_RBRACK;
      6: b = CH_SP;
      7: b = CH_TAB;
      8: b = CH_ALIGN;
      9: b = CH_BSLASH;
      10: b = 8'($urandom_range(8'h21, 8'h7E));           // any printable
      11: begin
        send_word(($urandom_range(0, 1) != 0) ? ACT_MORE : ACT_LESS, 8'($urandom));
        return;
      end
      default: begin
        send_word(2'($urandom_range(0, 3)), 8'($urandom));  // noise
        return;
      end
    endcase
    send_word(ACT_TEXT, b);
  endtask

  // well-formed lines: optional leading whitespace, optional '#', tokens,
  // then a newline byte, an end-of-line word or a backslash continuation
  task automatic test_code_lines(input int n_lines);
    for (int l = 0; l < n_lines; l++) begin
      repeat ($urandom_range(0, 2))
        send_word(ACT_TEXT, ($urandom_range(0, 1) != 0) ? CH_SP : CH_TAB);
      if ($urandom_range(0, 5) == 0) send_word(ACT_TEXT, CH_HASH);
      repeat ($urandom_range(1, 10)) send_token();
      case ($urandom_range(0, 3))
        0: begin
          send_word(ACT_TEXT, CH_BSLASH);
          if ($urandom_range(0, 1) != 0) send_word(ACT_TEXT, CH_NL);
          else send_word(ACT_EOL, 8'($urandom));
        end
        1: send_word(ACT_TEXT, CH_NL);
        default: send_word(ACT_EOL, 8'($urandom));
      endcase
    end
  endtask

  // push depth past its top, drive columns to saturation, then bring
  // depth back below zero
  task automatic test_depth_and_columns();
    send_word(ACT_EOL, 8'($urandom));
    repeat ($urandom_range(64, 68)) send_word(ACT_MORE, 8'($urandom));
    send_word(ACT_TEXT, CH_LBRACE);  // full-depth tab run, depth stays at max
    repeat ($urandom_range(64, 72)) send_word(ACT_TEXT, CH_TAB);
    send_word(ACT_TEXT, 8'h78);      // long space run; column pins at the top after 65 or more tabs
    send_word(ACT_TEXT, 8'h79);
    send_word(ACT_TEXT, CH_SP);      // whitespace past the top column
    send_word(ACT_TEXT, CH_ALIGN);
    send_word(ACT_TEXT, CH_TAB);
    send_word(ACT_TEXT, 8'h7A);
    send_word(ACT_TEXT, CH_NL);
    send_word(ACT_TEXT, CH_RBRACE);  // deep tab indent
    send_word(ACT_TEXT, CH_ALIGN);   // align target beyond the current column
    send_word(ACT_TEXT, 8'h41);
    send_word(ACT_EOL, 8'($urandom));
    repeat ($urandom_range(64, 68)) send_word(ACT_LESS, 8'($urandom));
    send_word(ACT_TEXT, CH_RBRACE);
    send_word(ACT_EOL, 8'($urandom));
  endtask

  // ---------------------------------------------------------------------
  // Sequence: reset, then three idling profiles
  // ---------------------------------------------------------------------

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender gaps lighter than receiver stalls
    send_idle_pct = 37;
    recv_idle_pct = 47;
    test_directed();
    test_code_lines(8);
    drain();

    // the other way round
    send_idle_pct = 47;
    recv_idle_pct = 37;
    test_depth_and_columns();
    drain();

    // back to back on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_code_lines(6);
    drain();

    repeat (SETTLE) @(posedge clk);
    if (run_q.size() != 0)
      report_mismatch($sformatf("%0d run words never arrived", run_q.size()));

    $display("Sent %0d input words and checked %0d run words", words_sent, runs_checked);
    $display("Deepest nesting %0d, widest column %0d, column clamps %0d",
             deepest, widest_col, col_sat_hits);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
